// File: rtl/mrw_pkg.sv
`default_nettype none

package mrw_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_MCU_SHAPE    = 3'd2,
    REG_MCUS_PER_ROW = 3'd3,
    REG_MCUS_PER_COL = 3'd4,
    REG_COLOR_MODE   = 3'd5,
    REG_REDUCE_MODE  = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    COLOR_GRAY   = 2'd0,
    COLOR_RGB888 = 2'd1,
    COLOR_RGB565 = 2'd2
  } color_mode_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_ROW_RANGE = 2'd1,
    ERR_FRAME     = 2'd2
  } error_code_t;

  localparam logic [1:0] BPP_GRAY   = 2'd1;
  localparam logic [1:0] BPP_RGB565 = 2'd2;
  localparam logic [1:0] BPP_RGB888 = 2'd3;

  localparam logic [7:0] COLUMN_LAST = 8'hff;
  localparam logic [8:0] ROW_LAST    = 9'h1ff;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [1:0]  mcu_shape;
    logic [8:0]  mcus_per_row;
    logic [8:0]  mcus_per_col;
    logic [1:0]  color_mode;
    logic        reduce_mode;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    image_width:  12'd320,
    image_height: 12'd240,
    mcu_shape:    2'd0,
    mcus_per_row: 9'd40,
    mcus_per_col: 9'd30,
    color_mode:   2'd0,
    reduce_mode:  1'b0
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] buffer_offset;
    logic       mcu_done;
  } sample_t;

  typedef struct packed {
    logic [17:0] byte_address;
    logic [23:0] pixel_bytes;
    logic [1:0]  byte_count;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } place_t;

endpackage

`default_nettype wire

// File: rtl/mrw_if.sv
`default_nettype none

interface mrw_sample_if import mrw_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] buffer_offset;
  logic       mcu_done;

  modport source(output valid, red, green, blue, buffer_offset, mcu_done, input ready);
  modport sink(input valid, red, green, blue, buffer_offset, mcu_done, output ready);
endinterface

interface mrw_pixel_if import mrw_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [17:0] byte_address;
  logic [23:0] pixel_bytes;
  logic [1:0]  byte_count;
  logic [1:0]  error_code;

  modport source(output valid, byte_address, pixel_bytes, byte_count, error_code,
                 input ready);
  modport sink(input valid, byte_address, pixel_bytes, byte_count, error_code,
               output ready);
endinterface

interface mrw_cfg_if import mrw_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/mrw_place.sv
`default_nettype none

module mrw_place import mrw_pkg::*; #(
  parameter int FRAME_BUFFER_BYTES = 230400
) (
  input  cfg_t       cfg,
  input  sample_t    sample,
  input  logic [7:0] mcu_column,
  input  logic [8:0] mcu_row,
  output place_t     place
);

  localparam logic [31:0] FB_LIMIT = 32'(FRAME_BUFFER_BYTES);

  logic        bx, by;
  logic [2:0]  row, col;
  logic [1:0]  bpp;
  logic        wide, tall;
  logic [11:0] px_full;
  logic [12:0] py_full;
  logic [8:0]  px_red;
  logic [9:0]  py_red;
  logic [9:0]  stride_red;
  logic [9:0]  height_red;
  logic [12:0] mul_a;
  logic [11:0] mul_b;
  logic [24:0] lin_prod;
  logic [17:0] lin;
  logic [17:0] addr;
  logic [11:0] frame_a, frame_b;
  logic [23:0] frame_prod;
  logic [25:0] frame;
  logic        frame_big, row_range;
  logic        in_shape, hit;
  logic [15:0] c565;
  logic [23:0] pix;

  assign bx   = sample.buffer_offset[6];
  assign by   = sample.buffer_offset[7];
  assign row  = sample.buffer_offset[5:3];
  assign col  = sample.buffer_offset[2:0];
  assign wide = cfg.mcu_shape[0];
  assign tall = cfg.mcu_shape[1];

  always_comb begin
    case (cfg.color_mode)
      COLOR_RGB888: bpp = BPP_RGB888;
      COLOR_RGB565: bpp = BPP_RGB565;
      default:      bpp = BPP_GRAY;
    endcase
  end

  assign px_full    = wide ? {mcu_column, bx, col} : {1'b0, mcu_column, col};
  assign py_full    = tall ? {mcu_row, by, row} : {1'b0, mcu_row, row};
  assign px_red     = wide ? {mcu_column, bx} : {1'b0, mcu_column};
  assign py_red     = tall ? {mcu_row, by} : {1'b0, mcu_row};
  assign stride_red = wide ? {cfg.mcus_per_row, 1'b0} : {1'b0, cfg.mcus_per_row};
  assign height_red = tall ? {cfg.mcus_per_col, 1'b0} : {1'b0, cfg.mcus_per_col};

  assign mul_a    = cfg.reduce_mode ? 13'(py_red) : py_full;
  assign mul_b    = cfg.reduce_mode ? 12'(stride_red) : cfg.image_width;
  assign lin_prod = mul_a * mul_b;
  assign lin      = lin_prod[17:0] + (cfg.reduce_mode ? 18'(px_red) : 18'(px_full));

  always_comb begin
    case (bpp)
      BPP_RGB888: addr = lin + {lin[16:0], 1'b0};
      BPP_RGB565: addr = {lin[16:0], 1'b0};
      default:    addr = lin;
    endcase
  end

  assign frame_a    = cfg.reduce_mode ? 12'(stride_red) : cfg.image_width;
  assign frame_b    = cfg.reduce_mode ? 12'(height_red) : cfg.image_height;
  assign frame_prod = frame_a * frame_b;

  always_comb begin
    case (bpp)
      BPP_RGB888: frame = 26'(frame_prod) + {1'b0, frame_prod, 1'b0};
      BPP_RGB565: frame = {1'b0, frame_prod, 1'b0};
      default:    frame = 26'(frame_prod);
    endcase
  end

  assign frame_big = {6'd0, frame} > FB_LIMIT;
  assign row_range = mcu_row >= cfg.mcus_per_col;
  assign in_shape  = (!bx || wide) && (!by || tall);

  always_comb begin
    if (cfg.reduce_mode) begin
      hit = (row == 3'd0) && (col == 3'd0) &&
            !((bpp == BPP_GRAY) && (sample.buffer_offset[7:6] != 2'd0));
    end else begin
      hit = (px_full < cfg.image_width) && (py_full < {1'b0, cfg.image_height});
    end
  end

  assign c565 = {sample.red[7:3], sample.green[7:2], sample.blue[7:3]};

  always_comb begin
    case (bpp)
      BPP_RGB888: pix = {sample.blue, sample.green, sample.red};
      BPP_RGB565: pix = {8'd0, c565[7:0], c565[15:8]};
      default:    pix = {16'd0, sample.red};
    endcase
  end

  always_comb begin
    place = '0;
    if (frame_big) begin
      place.emit           = 1'b1;
      place.res.error_code = ERR_FRAME;
    end else if (row_range) begin
      place.emit           = 1'b1;
      place.res.error_code = ERR_ROW_RANGE;
    end else if (in_shape && hit) begin
      place.emit             = 1'b1;
      place.res.byte_address = addr;
      place.res.pixel_bytes  = pix;
      place.res.byte_count   = bpp;
      place.res.error_code   = ERR_NONE;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mcu_to_raster_writer.sv
// A sample accepted goes to the input register; its result word is then registered in
// the result register, which drives the output.
// Throughput: one sample per cycle while the output is not stalled; one compute stage
// between the input register and the result register, with the address and frame-size
// multipliers side by side. Samples that produce no word (cropped, outside the MCU,
// reduce-mode skips) still pass through that stage.
// Reset: pipeline empty, MCU column and row zero, registers at their default values.
`default_nettype none

module mcu_to_raster_writer import mrw_pkg::*; #(
  parameter int FRAME_BUFFER_BYTES = 230400
) (
  input  wire         clk,
  input  wire         rst,
  mrw_cfg_if.sink     cfg,
  mrw_sample_if.sink  samples,
  mrw_pixel_if.source pixels
);

  cfg_t       regs;
  sample_t    s1;
  logic       s1_valid;
  result_t    res;
  logic       res_valid;
  logic [7:0] mcu_column;
  logic [8:0] mcu_row;
  place_t     place;
  logic       take;
  logic       adv;
  logic [8:0] column_step;
  logic       column_wrap;

  mrw_place #(
    .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
  ) u_place (
    .cfg        (regs),
    .sample     (s1),
    .mcu_column (mcu_column),
    .mcu_row    (mcu_row),
    .place      (place)
  );

  assign adv           = s1_valid && (!res_valid || pixels.ready);
  assign samples.ready = !s1_valid || adv;
  assign take          = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  assign column_step = {1'b0, mcu_column} + 9'd1;
  assign column_wrap = (column_step >= regs.mcus_per_row) || (mcu_column == COLUMN_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs       <= CFG_RESET;
      s1_valid   <= 1'b0;
      res_valid  <= 1'b0;
      mcu_column <= '0;
      mcu_row    <= '0;
    end else begin
      if (cfg.valid) begin
        case (reg_index_t'(cfg.index))
          REG_IMAGE_WIDTH:  regs.image_width  <= cfg.data[11:0];
          REG_IMAGE_HEIGHT: regs.image_height <= cfg.data[11:0];
          REG_MCU_SHAPE:    regs.mcu_shape    <= cfg.data[1:0];
          REG_MCUS_PER_ROW: regs.mcus_per_row <= cfg.data[8:0];
          REG_MCUS_PER_COL: regs.mcus_per_col <= cfg.data[8:0];
          REG_COLOR_MODE:   regs.color_mode   <= cfg.data[1:0];
          REG_REDUCE_MODE:  regs.reduce_mode  <= cfg.data[0];
          default: ;
        endcase
      end
      if (take) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv && place.emit) begin
        res_valid <= 1'b1;
      end else if (pixels.ready) begin
        res_valid <= 1'b0;
      end
      if (adv && s1.mcu_done) begin
        if (column_wrap) begin
          mcu_column <= '0;
          if (mcu_row != ROW_LAST) begin
            mcu_row <= mcu_row + 9'd1;
          end
        end else begin
          mcu_column <= column_step[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1.red           <= samples.red;
      s1.green         <= samples.green;
      s1.blue          <= samples.blue;
      s1.buffer_offset <= samples.buffer_offset;
      s1.mcu_done      <= samples.mcu_done;
    end
    if (adv && place.emit) begin
      res <= place.res;
    end
  end

  assign pixels.valid        = res_valid;
  assign pixels.byte_address = res.byte_address;
  assign pixels.pixel_bytes  = res.pixel_bytes;
  assign pixels.byte_count   = res.byte_count;
  assign pixels.error_code   = res.error_code;

  a_err_no_bytes: assert property (@(posedge clk) disable iff (rst)
    pixels.valid && (pixels.error_code != ERR_NONE) |->
      (pixels.byte_count == 2'd0) && (pixels.byte_address == 18'd0))
    else $error("error word carries pixel bytes");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && res_valid && !pixels.ready |=> s1_valid && $stable(s1))
    else $error("staged sample lost under output stall");

  a_row_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> mcu_row >= $past(mcu_row))
    else $error("mcu row moved backward");

  a_column_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (mcu_column != $past(mcu_column)) |->
      (mcu_column == 8'($past(mcu_column) + 8'd1)) || (mcu_column == 8'd0))
    else $error("mcu column jumped");

endmodule

`default_nettype wire

// File: verif/mcu_to_raster_writer_test.sv
`timescale 1ns / 1ps

module mcu_to_raster_writer_test import mrw_pkg::*; ();

  localparam int FRAME_BYTES = 230400;
  localparam int QUIET_LIMIT = 20000;

  localparam logic [1:0] SHAPE_8X8   = 2'd0;
  localparam logic [1:0] SHAPE_16X8  = 2'd1;
  localparam logic [1:0] SHAPE_8X16  = 2'd2;
  localparam logic [1:0] SHAPE_16X16 = 2'd3;

  typedef enum int {PACE_FULL, PACE_SPARSE_IN, PACE_SLOW_OUT, PACE_BOTH} pace_t;

  class raster_placement;
    cfg_t            regs;
    logic [7:0]      column;
    logic [8:0]      row;
    result_t         due_pixels[$];
    int              mismatches;
    longint unsigned frame_limit;

    function new(longint unsigned limit);
      regs = CFG_RESET;
      column = '0;
      row = '0;
      mismatches = 0;
      frame_limit = limit;
    endfunction

    function int pending();
      return due_pixels.size();
    endfunction

    function void write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_IMAGE_WIDTH:  regs.image_width = value;
        REG_IMAGE_HEIGHT: regs.image_height = value;
        REG_MCU_SHAPE:    regs.mcu_shape = value[1:0];
        REG_MCUS_PER_ROW: regs.mcus_per_row = value[8:0];
        REG_MCUS_PER_COL: regs.mcus_per_col = value[8:0];
        REG_COLOR_MODE:   regs.color_mode = value[1:0];
        REG_REDUCE_MODE:  regs.reduce_mode = value[0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] off, logic done);
      int unsigned     mw, mh, rb, cb, bpp, bx, by, mpr, mpc, next;
      longint unsigned frame, px, py, addr;
      logic [15:0]     c565;
      logic [23:0]     pix;
      logic [1:0]      count;
      error_code_t     err;
      bit              emit;
      result_t         res;
      mw = regs.mcu_shape[0] ? 16 : 8;
      mh = regs.mcu_shape[1] ? 16 : 8;
      rb = mw / 8;
      cb = mh / 8;
      case (regs.color_mode)
        COLOR_RGB888: begin
          bpp = 3;
          count = BPP_RGB888;
        end
        COLOR_RGB565: begin
          bpp = 2;
          count = BPP_RGB565;
        end
        default: begin
          bpp = 1;
          count = BPP_GRAY;
        end
      endcase
      bx = off[6];
      by = off[7];
      mpr = regs.mcus_per_row;
      mpc = regs.mcus_per_col;
      if (regs.reduce_mode) begin
        frame = mpr;
        frame = frame * rb * bpp * mpc * cb;
      end else begin
        frame = regs.image_width;
        frame = frame * bpp * regs.image_height;
      end
      err = ERR_NONE;
      if (frame > frame_limit) err = ERR_FRAME;
      else if (row >= regs.mcus_per_col) err = ERR_ROW_RANGE;

      c565 = {r[7:3], g[7:2], b[7:3]};
      case (bpp)
        3: pix = {b, g, r};
        2: pix = {8'h00, c565[7:0], c565[15:8]};
        default: pix = {16'h0000, r};
      endcase

      emit = 1'b0;
      addr = 0;
      if (err == ERR_NONE && bx < rb && by < cb) begin
        if (regs.reduce_mode) begin
          if (off[5:0] == 6'd0 && !(bpp == 1 && off[7:6] != 2'd0)) begin
            px = column * rb + bx;
            py = row * cb + by;
            addr = (py * mpr * rb + px) * bpp;
            emit = 1'b1;
          end
        end else begin
          px = column * mw + bx * 8 + off[2:0];
          py = row * mh + by * 8 + off[5:3];
          if (px < regs.image_width && py < regs.image_height) begin
            addr = (py * regs.image_width + px) * bpp;
            emit = 1'b1;
          end
        end
      end

      res = '0;
      if (err != ERR_NONE) begin
        res.error_code = err;
        due_pixels.push_back(res);
      end else if (emit) begin
        res.byte_address = addr[17:0];
        res.pixel_bytes = pix;
        res.byte_count = count;
        res.error_code = ERR_NONE;
        due_pixels.push_back(res);
      end

      if (done) begin
        next = column + 1;
        if (next >= mpr || next > COLUMN_LAST) begin
          column = '0;
          if (row != ROW_LAST) row = row + 1;
        end else begin
          column = next[7:0];
        end
      end
    endfunction

    task flag(string msg);
      if (mismatches < 40) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task match_pixel(logic [17:0] addr, logic [23:0] bytes, logic [1:0] count,
                     logic [1:0] code);
      result_t want;
      if (due_pixels.size() == 0) begin
        flag($sformatf("unexpected word addr %0h bytes %0h count %0d err %0d",
                       addr, bytes, count, code));
        return;
      end
      want = due_pixels.pop_front();
      if (addr !== want.byte_address)
        flag($sformatf("byte_address %0h, want %0h", addr, want.byte_address));
      if (bytes !== want.pixel_bytes)
        flag($sformatf("pixel_bytes %0h, want %0h (addr %0h)", bytes, want.pixel_bytes,
                       want.byte_address));
      if (count !== want.byte_count)
        flag($sformatf("byte_count %0d, want %0d (addr %0h)", count, want.byte_count,
                       want.byte_address));
      if (code !== want.error_code)
        flag($sformatf("error_code %0d, want %0d", code, want.error_code));
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              quiet_cycles = 0;
  int unsigned     samples_sent = 0;
  raster_placement model;

  mrw_cfg_if    cfg_bus();
  mrw_sample_if sample_bus();
  mrw_pixel_if  pixel_bus();

  mcu_to_raster_writer #(.FRAME_BUFFER_BYTES(FRAME_BYTES)) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_bus),
    .samples(sample_bus),
    .pixels(pixel_bus)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    pixel_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_bus.valid && pixel_bus.ready)
        model.match_pixel(pixel_bus.byte_address, pixel_bus.pixel_bytes,
                          pixel_bus.byte_count, pixel_bus.error_code);
      if (sample_bus.valid && sample_bus.ready)
        model.take_sample(sample_bus.red, sample_bus.green, sample_bus.blue,
                          sample_bus.buffer_offset, sample_bus.mcu_done);
      if (cfg_bus.valid && cfg_bus.ready)
        model.write_reg(reg_index_t'(cfg_bus.index), cfg_bus.data);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) || (pixel_bus.valid && pixel_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_pace(pace_t pace);
    case (pace)
      PACE_SPARSE_IN: begin
        idle_pct = 81;
        stall_pct = 0;
      end
      PACE_SLOW_OUT: begin
        idle_pct = 0;
        stall_pct = 81;
      end
      PACE_BOTH: begin
        idle_pct = 10;
        stall_pct = 10;
      end
      default: begin
        idle_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  task automatic send_sample(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] off,
                             logic done);
    while ($urandom_range(0, 99) < idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.red <= r;
    sample_bus.green <= g;
    sample_bus.blue <= b;
    sample_bus.buffer_offset <= off;
    sample_bus.mcu_done <= done;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    samples_sent++;
  endtask

  // hold off until every word is out and the pipeline has flushed
  task automatic drain();
    sample_bus.valid <= 1'b0;
    @(posedge clk);
    while (model.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, int unsigned value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
  endtask

  task automatic set_config(int unsigned width, int unsigned height, logic [1:0] shape,
                            int unsigned mpr, int unsigned mpc, color_mode_t color,
                            logic reduce);
    drain();
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_MCU_SHAPE, shape);
    write_reg(REG_MCUS_PER_ROW, mpr);
    write_reg(REG_MCUS_PER_COL, mpc);
    write_reg(REG_COLOR_MODE, color);
    write_reg(REG_REDUCE_MODE, reduce);
    cfg_bus.valid <= 1'b0;
  endtask

  // place the image edges near the current MCU row so cropping and row range get hit
  task automatic random_config();
    logic [1:0]  shape;
    color_mode_t color;
    logic        reduce;
    int unsigned mw, mh, bpp, row, mpc, height, wmax, width, mpr, span;
    shape = 2'($urandom_range(0, 3));
    mw = shape[0] ? 16 : 8;
    mh = shape[1] ? 16 : 8;
    color = color_mode_t'($urandom_range(0, 2));
    bpp = (color == COLOR_RGB888) ? 3 : (color == COLOR_RGB565) ? 2 : 1;
    reduce = ($urandom_range(0, 3) == 0);
    row = model.row;
    if ($urandom_range(0, 5) == 0) begin
      mpc = $urandom_range(1, 256);
    end else begin
      mpc = row + $urandom_range(1, 4);
      if (mpc > 256) mpc = 256;
    end
    if (row * mh < 4000) begin
      height = row * mh + $urandom_range(1, 3 * mh);
      if (height > 4095) height = 4095;
    end else begin
      height = $urandom_range(1, 4095);
    end
    wmax = FRAME_BYTES / (bpp * height);
    if (wmax > 4095) wmax = 4095;
    span = (wmax < 6 * mw) ? wmax : 6 * mw;
    if ($urandom_range(0, 7) == 0) width = $urandom_range(1, 4095);
    else width = $urandom_range(1, span);
    mpr = (width + mw - 1) / mw;
    if ($urandom_range(0, 3) == 0) mpr = $urandom_range(1, 256);
    if (mpr > 256) mpr = 256;
    set_config(width, height, shape, mpr, mpc, color, reduce);
  endtask

  task automatic send_mcus(int unsigned count);
    int unsigned start, kind, len, rb, cb, bx, by, pos;
    logic [1:0]  shape;
    logic [7:0]  off;
    logic        broken;
    start = samples_sent;
    shape = model.regs.mcu_shape;
    rb = shape[0] ? 2 : 1;
    cb = shape[1] ? 2 : 1;
    while (samples_sent - start < count) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        send_sample(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom));
      end else if (kind == 1) begin
        for (int blk = 0; blk < 4; blk++) begin
          if ((blk % 2) < rb && (blk / 2) < cb) begin
            for (int k = 0; k < 64; k++)
              send_sample(8'($urandom), 8'($urandom), 8'($urandom), 8'(blk * 64 + k),
                          (blk == shape && k == 63));
          end
        end
      end else begin
        len = $urandom_range(1, 12);
        broken = (kind == 2);
        for (int i = 0; i < len; i++) begin
          bx = $urandom_range(0, rb - 1);
          by = $urandom_range(0, cb - 1);
          if ($urandom_range(0, 15) == 0) begin
            bx = $urandom_range(0, 1);
            by = $urandom_range(0, 1);
          end
          pos = (model.regs.reduce_mode && $urandom_range(0, 1)) ? 0 : $urandom_range(0, 63);
          off = 8'(by * 128 + bx * 64 + pos);
          send_sample(8'($urandom), 8'($urandom), 8'($urandom), off,
                      (i == len - 1) && !broken);
        end
      end
    end
  endtask

  initial begin
    model = new(FRAME_BYTES);
    sample_bus.valid = 1'b0;
    sample_bus.red = '0;
    sample_bus.green = '0;
    sample_bus.blue = '0;
    sample_bus.buffer_offset = '0;
    sample_bus.mcu_done = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_IMAGE_WIDTH;
    cfg_bus.data = '0;
    pixel_bus.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // defaults: gray 320x240, single-block MCU
    send_sample(8'hff, 8'h00, 8'h00, 8'd0, 1'b0);
    send_sample(8'h00, 8'hff, 8'hff, 8'd63, 1'b0);
    send_sample(8'h5a, 8'ha5, 8'h3c, 8'd64, 1'b0);
    send_sample(8'hff, 8'hff, 8'hff, 8'd255, 1'b1);

    // widest image, one line tall, 16x16 MCU, RGB888
    set_config(4095, 1, SHAPE_16X16, 256, 256, COLOR_RGB888, 1'b0);
    send_sample(8'hff, 8'hff, 8'hff, 8'd0, 1'b0);
    send_sample(8'h01, 8'h02, 8'h03, 8'd8, 1'b0);
    send_sample(8'h80, 8'h40, 8'h20, 8'd255, 1'b0);
    send_sample(8'h00, 8'h00, 8'h00, 8'd71, 1'b1);

    // one pixel wide, tallest image, 8x16 MCU, RGB565
    set_config(1, 4095, SHAPE_8X16, 1, 256, COLOR_RGB565, 1'b0);
    send_sample(8'hff, 8'hff, 8'hff, 8'd0, 1'b1);
    send_sample(8'hff, 8'h00, 8'h00, 8'd0, 1'b0);
    send_sample(8'h00, 8'hff, 8'h00, 8'd128, 1'b0);
    send_sample(8'h00, 8'h00, 8'hff, 8'd64, 1'b0);
    send_sample(8'h07, 8'h03, 8'hf8, 8'd1, 1'b0);
    send_sample(8'hf8, 8'hfc, 8'h07, 8'd136, 1'b1);

    // frame larger than the buffer
    set_config(4095, 4095, SHAPE_8X8, 1, 256, COLOR_GRAY, 1'b0);
    send_sample(8'h11, 8'h22, 8'h33, 8'd0, 1'b0);
    send_sample(8'h44, 8'h55, 8'h66, 8'd9, 1'b1);

    // MCU row past the image
    set_config(64, 64, SHAPE_16X8, 2, 1, COLOR_GRAY, 1'b0);
    send_sample(8'h77, 8'h88, 8'h99, 8'd0, 1'b0);
    send_sample(8'haa, 8'hbb, 8'hcc, 8'd64, 1'b1);

    // reduce mode, color then gray
    set_config(64, 64, SHAPE_16X16, 4, 256, COLOR_RGB888, 1'b1);
    send_sample(8'h10, 8'h20, 8'h30, 8'd0, 1'b0);
    send_sample(8'h40, 8'h50, 8'h60, 8'd64, 1'b0);
    send_sample(8'h70, 8'h80, 8'h90, 8'd128, 1'b0);
    send_sample(8'ha0, 8'hb0, 8'hc0, 8'd9, 1'b0);
    send_sample(8'hd0, 8'he0, 8'hf0, 8'd192, 1'b1);
    set_config(64, 64, SHAPE_16X16, 4, 256, COLOR_GRAY, 1'b1);
    send_sample(8'hfe, 8'h00, 8'h00, 8'd0, 1'b0);
    send_sample(8'h01, 8'h00, 8'h00, 8'd64, 1'b1);

    for (int p = 0; p < 8; p++) begin
      random_config();
      set_pace(pace_t'(p % 4));
      send_mcus(60);
    end

    drain();
    if (model.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: mcu_to_raster_writer.f
rtl/mrw_pkg.sv
rtl/mrw_if.sv
rtl/mrw_place.sv
rtl/mcu_to_raster_writer.sv
verif/mcu_to_raster_writer_test.sv
